[src/fpba_pkg.sv]
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared widths, register codes, fit modes and the types that pass between
// the front end, the back end and the top level of the block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int unsigned BLOCKS_DEFAULT = 16;

  localparam int unsigned AMOUNT_W   = 16;
  localparam int unsigned BLK_IDX_W  = 4;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // input kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  // fit modes, the unused code behaves as first fit
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 8'd1;

  localparam logic [MODE_W-1:0]  FIT_MODE_RST    = MODE_FIRST;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

  typedef struct packed {
    logic                 is_req;
    logic [BLK_IDX_W-1:0] idx;
    logic [AMOUNT_W-1:0]  amount;
  } item_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [MODE_W-1:0]  fit_mode;
    logic [COUNT_W-1:0] block_count;
  } cfg_t;

endpackage

[src/fpba_if.sv]
// ----------------------------------------------------------------------------
// fpba interfaces
// Valid/ready channels of the block allocator: input items, results and
// register writes.
// ----------------------------------------------------------------------------
interface fpba_in_if import fpba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [BLK_IDX_W-1:0] block_index;
  logic [AMOUNT_W-1:0]  amount;

  modport source (output valid, kind, block_index, amount, input ready);
  modport sink   (input valid, kind, block_index, amount, output ready);
endinterface

interface fpba_out_if import fpba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 granted;
  logic [BLK_IDX_W-1:0] chosen_block;

  modport source (output valid, granted, chosen_block, input ready);
  modport sink   (input valid, granted, chosen_block, output ready);
endinterface

interface fpba_cfg_if import fpba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/fit_policy_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core
// First / best / worst fit allocator over a table of free block sizes.
// ----------------------------------------------------------------------------
// A load beat writes one entry of the free-size table and gives no result; a
// request beat gives exactly one result (granted plus chosen block). The
// front end takes beats into a two-entry queue, so the input keeps flowing,
// until the queue is full, while the back end works and while a result
// waits in the output register. The back end reads the table through one
// RAM read port, one entry per cycle; a request scans n = min(block_count,
// BLOCKS) entries once it leaves the queue, and the finish step waits for as
// long as the previous result is still held in the output register. Entries
// never loaded since reset read as zero (a per-entry valid bit, cleared by
// reset), so no clearing pass is needed. Ties go to the lowest index,
// fit_mode 3 acts as first fit, a block_count above BLOCKS scans the whole
// table, and loads aimed beyond the table are dropped at the front.
// Registers must be written only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_core import fpba_pkg::*; #(
  parameter int unsigned BLOCKS = BLOCKS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpba_in_if.sink    in_i,
  fpba_out_if.source out_o,
  fpba_cfg_if.sink   cfg_i
);

  logic [MODE_W-1:0]  fit_mode_q;
  logic [COUNT_W-1:0] block_count_q;
  cfg_t               cfg;
  queue_head_t        head;
  logic               pop;

  // register writes are always taken, unknown indexes do nothing
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= FIT_MODE_RST;
      block_count_q <= BLOCK_COUNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FIT_MODE:    fit_mode_q    <= cfg_i.data[MODE_W-1:0];
        REG_BLOCK_COUNT: block_count_q <= cfg_i.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.fit_mode    = fit_mode_q;
  assign cfg.block_count = block_count_q;

  // front end: accept, filter and queue beats
  fpba_front #(
    .BLOCKS (BLOCKS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  // back end: table, scan engine and result register
  fpba_back #(
    .BLOCKS (BLOCKS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .cfg_i  (cfg),
    .out_o  (out_o)
  );

endmodule

[src/fpba_ram.sv]
// ----------------------------------------------------------------------------
// fpba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fpba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/fpba_front.sv]
// ----------------------------------------------------------------------------
// fpba_front
// Accepts input beats, drops loads aimed outside the table and queues the
// rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fpba_front import fpba_pkg::*; #(
  parameter int unsigned BLOCKS = BLOCKS_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fpba_in_if.sink       in_i,
  output queue_head_t   head_o,
  input  logic          pop_i
);

  localparam int unsigned DEPTH = 2;

  item_t       mem_q [DEPTH];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        keep, push;

  // a load outside the table is taken and forgotten
  assign keep  = (in_i.kind == KIND_REQ) || (32'(in_i.block_index) < 32'(BLOCKS));
  assign push  = in_i.valid && in_i.ready && keep;
  assign in_i.ready = (cnt_q != 2'(DEPTH));

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{is_req: in_i.kind, idx: in_i.block_index, amount: in_i.amount};
    end
  end

endmodule

[src/fpba_back.sv]
// ----------------------------------------------------------------------------
// fpba_back
// Executes queued items: loads write the size table, requests scan it one
// entry per cycle, reduce the chosen entry and register the result.
// ----------------------------------------------------------------------------
module fpba_back import fpba_pkg::*; #(
  parameter int unsigned BLOCKS = BLOCKS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_head_t head_i,
  output logic        pop_o,
  input  cfg_t        cfg_i,
  fpba_out_if.source  out_o
);

  localparam int unsigned IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(BLOCKS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     ptr_q, n_q, eff_n;
  logic [AMOUNT_W-1:0]  amt_q;
  logic [MODE_W-1:0]    mode_q;
  logic                 cmp_vld_q, found_q;
  logic [IDX_W-1:0]     cmp_idx_q, best_idx_q;
  logic [AMOUNT_W-1:0]  best_size_q;
  logic [BLOCKS-1:0]    valid_q;
  logic                 out_vld_q, out_granted_q;
  logic [BLK_IDX_W-1:0] out_blk_q;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [AMOUNT_W-1:0]  ram_wdata, ram_rdata, cur_size;
  logic                 issue, fits, take, out_free, fin_fire, start_req;

  fpba_ram #(
    .WIDTH (AMOUNT_W),
    .DEPTH (BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign eff_n = (32'(cfg_i.block_count) > 32'(BLOCKS)) ? CNT_W'(BLOCKS)
                                                        : CNT_W'(cfg_i.block_count);

  // entries never written read as zero
  assign cur_size = valid_q[cmp_idx_q] ? ram_rdata : '0;
  assign fits     = (cur_size >= amt_q);
  assign take     = cmp_vld_q && fits &&
                    (!found_q ||
                     ((mode_q == MODE_BEST)  && (cur_size < best_size_q)) ||
                     ((mode_q == MODE_WORST) && (cur_size > best_size_q)));
  assign issue    = (state_q == S_SCAN) && (ptr_q < n_q);
  assign out_free = !out_vld_q || out_o.ready;
  assign start_req = (state_q == S_IDLE) && head_i.valid && (head_i.item.is_req == KIND_REQ);

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = best_idx_q;
    ram_wdata = best_size_q - amt_q;
    fin_fire  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.item.is_req == KIND_LOAD) begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(head_i.item.idx);
            ram_wdata = head_i.item.amount;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if ((ptr_q == n_q) && !cmp_vld_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          fin_fire = 1'b1;
          ram_we   = found_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (start_req) begin
        cmp_vld_q <= 1'b0;
        found_q   <= 1'b0;
      end else if (state_q == S_SCAN) begin
        cmp_vld_q <= issue;
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (fin_fire) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_req) begin
      ptr_q  <= '0;
      n_q    <= eff_n;
      amt_q  <= head_i.item.amount;
      mode_q <= cfg_i.fit_mode;
    end else if (issue) begin
      ptr_q <= CNT_W'(ptr_q + 1'b1);
    end
    if (issue) begin
      cmp_idx_q <= ptr_q[IDX_W-1:0];
    end
    if (take) begin
      best_idx_q  <= cmp_idx_q;
      best_size_q <= cur_size;
    end
    if (fin_fire) begin
      out_granted_q <= found_q;
      out_blk_q     <= found_q ? BLK_IDX_W'(best_idx_q) : '0;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.granted      = out_granted_q;
  assign out_o.chosen_block = out_blk_q;

  // the table is never written while a scan is in flight
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !ram_we)
    else $error("size table written during a scan");

  // a chosen entry always lies inside the scanned range
  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (32'(best_idx_q) < 32'(n_q)))
    else $error("chosen entry outside scanned range");

  // compare data only exists while scanning
  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == S_SCAN))
    else $error("compare stage active outside scan");

  // a new result only comes out of the finish step
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == S_FIN))
    else $error("result raised outside finish step");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fit_policy_block_allocator_core: drives load and
// request beats over valid/ready channels with random gaps and output stalls,
// predicts each grant from a local copy of the free-size table or a pinned
// script row, and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import fpba_pkg::*;

  localparam int unsigned BLOCKS        = 16;
  localparam int unsigned SETTLE_CYCLES = 2 * BLOCKS + 8;  // covers one full scan
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_ITEMS   = 125;

  // codes the package does not name
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

  typedef enum logic [1:0] {ST_LOAD, ST_REQ, ST_CFG} step_e;

  // one row of the directed script; sel is the block index or register index
  typedef struct packed {
    step_e                op;
    logic [7:0]           sel;
    logic [AMOUNT_W-1:0]  value;
    logic                 pinned;
    logic                 granted;
    logic [BLK_IDX_W-1:0] blk;
  } step_t;

  typedef struct packed {
    logic                 granted;
    logic [BLK_IDX_W-1:0] blk;
  } grant_t;

  logic clk_i;
  logic rst_ni;

  fpba_in_if  in_if ();
  fpba_out_if out_if ();
  fpba_cfg_if cfg_if ();

  fit_policy_block_allocator_core #(
    .BLOCKS(BLOCKS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // local copy of the allocator state
  logic [AMOUNT_W-1:0] free_tab [BLOCKS];
  logic [MODE_W-1:0]   mdl_mode  = FIT_MODE_RST;
  logic [COUNT_W-1:0]  mdl_count = BLOCK_COUNT_RST;

  grant_t grants_due [$];  // grants still owed by the block, oldest first
  int     errors = 0;
  bit     calm   = 1'b0;   // no gaps and no stalls while set

  // hand-typed expectation for the beat being offered
  bit     pin_valid = 1'b0;
  grant_t pin_want  = '0;

  // directed script: extremes, every mode, each corner case
  step_t script [25] = '{
    // zero request on the cleared table fits entry 0
    '{ST_REQ,  8'd0, 16'd0,      1'b1, 1'b1, 4'd0},
    // nothing loaded yet, so nothing fits
    '{ST_REQ,  8'd0, 16'd1,      1'b1, 1'b0, 4'd0},
    '{ST_LOAD, 8'd15, 16'hFFFF,  1'b0, 1'b0, 4'd0},
    '{ST_LOAD, 8'd0, 16'd100,    1'b0, 1'b0, 4'd0},
    '{ST_LOAD, 8'd5, 16'd50,     1'b0, 1'b0, 4'd0},
    '{ST_LOAD, 8'd9, 16'd200,    1'b0, 1'b0, 4'd0},
    // full-scale request, only the last entry is big enough
    '{ST_REQ,  8'd7, 16'hFFFF,   1'b1, 1'b1, 4'd15},
    '{ST_REQ,  8'd3, 16'd40,     1'b0, 1'b0, 4'd0},
    '{ST_CFG,  REG_FIT_MODE, 16'(MODE_BEST),  1'b0, 1'b0, 4'd0},
    '{ST_REQ,  8'd0, 16'd45,     1'b0, 1'b0, 4'd0},
    '{ST_CFG,  REG_FIT_MODE, 16'(MODE_WORST), 1'b0, 1'b0, 4'd0},
    '{ST_REQ,  8'd0, 16'd10,     1'b0, 1'b0, 4'd0},
    // spare mode code with all upper data bits set, behaves as first fit
    '{ST_CFG,  REG_FIT_MODE, 16'h00FF, 1'b0, 1'b0, 4'd0},
    '{ST_REQ,  8'd0, 16'd10,     1'b0, 1'b0, 4'd0},
    // empty scan window never grants
    '{ST_CFG,  REG_BLOCK_COUNT, 16'd0, 1'b0, 1'b0, 4'd0},
    '{ST_REQ,  8'd15, 16'd0,     1'b1, 1'b0, 4'd0},
    // oversized count clamps to the table
    '{ST_CFG,  REG_BLOCK_COUNT, 16'h00FF, 1'b0, 1'b0, 4'd0},
    // write to a register that does not exist
    '{ST_CFG,  REG_UNUSED, 16'h0001, 1'b0, 1'b0, 4'd0},
    '{ST_REQ,  8'd0, 16'd0,      1'b0, 1'b0, 4'd0},
    '{ST_LOAD, 8'd3, 16'hAAAA,   1'b0, 1'b0, 4'd0},
    '{ST_LOAD, 8'd10, 16'h5555,  1'b0, 1'b0, 4'd0},
    '{ST_CFG,  REG_FIT_MODE, 16'(MODE_BEST), 1'b0, 1'b0, 4'd0},
    '{ST_CFG,  REG_BLOCK_COUNT, 16'd1, 1'b0, 1'b0, 4'd0},
    '{ST_REQ,  8'd0, 16'd1,      1'b0, 1'b0, 4'd0},
    // window of one entry that is far too small
    '{ST_REQ,  8'd0, 16'hFFFF,   1'b1, 1'b0, 4'd0}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("fit_policy_block_allocator_core verification failed");
    $finish;
  end

  // applies one beat to the local table; returns 1 when a result is owed
  function automatic bit predict_alloc(input item_t it, output grant_t res);
    int n;
    int pick;
    bit hit;
    res  = '0;
    pick = 0;
    hit  = 1'b0;
    if (it.is_req == KIND_LOAD) begin
      if (int'(it.idx) < BLOCKS) free_tab[it.idx] = it.amount;
      return 1'b0;
    end
    n = (int'(mdl_count) > BLOCKS) ? BLOCKS : int'(mdl_count);
    for (int j = 0; j < n; j++) begin
      if (free_tab[j] >= it.amount) begin
        if (!hit) begin
          hit  = 1'b1;
          pick = j;
          // first fit, spare code included, stops at the first candidate
          if (mdl_mode != MODE_BEST && mdl_mode != MODE_WORST) break;
        end else if ((mdl_mode == MODE_BEST  && free_tab[j] < free_tab[pick]) ||
                     (mdl_mode == MODE_WORST && free_tab[j] > free_tab[pick])) begin
          // strict compare keeps the lowest index on ties
          pick = j;
        end
      end
    end
    if (hit) begin
      free_tab[pick] = free_tab[pick] - it.amount;
      res.granted    = 1'b1;
      res.blk        = pick[BLK_IDX_W-1:0];
    end
    return 1'b1;
  endfunction

  // observes all three channels at the rising edge, before the block updates
  always @(posedge clk_i) begin
    item_t  it;
    grant_t want;
    grant_t got;
    if (rst_ni) begin
      // result beat against the oldest owed grant
      if (out_if.valid && out_if.ready) begin
        got.granted = out_if.granted;
        got.blk     = out_if.chosen_block;
        if (grants_due.size() == 0) begin
          $display("%0t: unexpected result beat, granted %0b block %0d",
                   $time, got.granted, got.blk);
          errors++;
        end else begin
          want = grants_due.pop_front();
          if (got.granted !== want.granted) begin
            $display("%0t: granted expected %0b actual %0b",
                     $time, want.granted, got.granted);
            errors++;
          end
          if (got.blk !== want.blk) begin
            $display("%0t: chosen_block expected %0d actual %0d",
                     $time, want.blk, got.blk);
            errors++;
          end
        end
      end
      // accepted input beat updates the table and may owe a grant
      if (in_if.valid && in_if.ready) begin
        it.is_req = in_if.kind;
        it.idx    = in_if.block_index;
        it.amount = in_if.amount;
        if (predict_alloc(it, want)) begin
          if (pin_valid) want = pin_want;
          grants_due.push_back(want);
        end
      end
      // register writes, unknown indexes fall through
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == REG_FIT_MODE) begin
          mdl_mode = cfg_if.data[MODE_W-1:0];
        end else if (cfg_if.index == REG_BLOCK_COUNT) begin
          mdl_count = cfg_if.data[COUNT_W-1:0];
        end
      end
    end
  end

  // mostly short waits, now and then a long one
  function automatic int pick_wait();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result-side back pressure
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        out_if.ready <= 1'b0;
        stall_left = pick_wait() - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // offers one input beat; entered and left at a falling edge
  task automatic push_item(input logic kind, input logic [BLK_IDX_W-1:0] idx,
                           input logic [AMOUNT_W-1:0] amt, input bit pinned = 1'b0,
                           input logic pg = 1'b0, input logic [BLK_IDX_W-1:0] pb = '0);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 60) ? 0 : pick_wait();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pin_valid        = pinned;
    pin_want.granted = pg;
    pin_want.blk     = pb;
    in_if.valid       <= 1'b1;
    in_if.kind        <= kind;
    in_if.block_index <= idx;
    in_if.amount      <= amt;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    pin_valid = 1'b0;
  endtask

  // drains the block so registers can be written safely
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (grants_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // one register write beat, with valid dropped again before returning
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // random beat: loads refresh the table, requests sized to hit and miss
  task automatic random_item();
    int r;
    logic [AMOUNT_W-1:0]  amt;
    logic [BLK_IDX_W-1:0] idx;
    idx = BLK_IDX_W'($urandom_range(0, BLOCKS - 1));
    r   = $urandom_range(0, 99);
    if (r < 35) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        amt = AMOUNT_W'($urandom_range(1, 8) * 8);  // coarse sizes make ties
      end else if (r < 80) begin
        amt = AMOUNT_W'($urandom);
      end else begin
        case ($urandom_range(0, 3))
          0:       amt = 16'h0000;
          1:       amt = 16'hFFFF;
          2:       amt = 16'h8000;
          default: amt = 16'h7FFF;
        endcase
      end
      push_item(KIND_LOAD, idx, amt);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 15)      amt = '0;
      else if (r < 55) amt = AMOUNT_W'($urandom_range(1, 64));
      else if (r < 75) amt = free_tab[$urandom_range(0, BLOCKS - 1)];  // exact fit
      else if (r < 90) amt = AMOUNT_W'($urandom);
      else             amt = 16'hFFFF;
      push_item(KIND_REQ, idx, amt);
    end
  endtask

  // stimulus and end of run
  initial begin
    int sent;
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] cnt;
    foreach (free_tab[i]) free_tab[i] = '0;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_LOAD;
    in_if.block_index = '0;
    in_if.amount      = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    sent              = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed script
    foreach (script[i]) begin
      case (script[i].op)
        ST_CFG: begin
          wait_idle();
          write_reg(script[i].sel, script[i].value[CFG_DATA_W-1:0]);
        end
        ST_LOAD: begin
          push_item(KIND_LOAD, script[i].sel[BLK_IDX_W-1:0], script[i].value);
        end
        default: begin
          push_item(KIND_REQ, script[i].sel[BLK_IDX_W-1:0], script[i].value,
                    script[i].pinned, script[i].granted, script[i].blk);
        end
      endcase
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0:       begin mode = MODE_FIRST; cnt = 5'd16; end
        1:       begin mode = MODE_BEST;  cnt = 5'd16; end
        2:       begin mode = MODE_WORST; cnt = 5'd16; end
        3:       begin mode = MODE_SPARE; cnt = 5'd31; end
        4:       begin mode = MODE_BEST;  cnt = 5'd1;  end
        5:       begin mode = MODE_WORST; cnt = 5'd0;  end
        default: begin
          mode = MODE_W'($urandom_range(0, 3));
          cnt  = ($urandom_range(0, 1) != 0) ? 5'd16 : COUNT_W'($urandom_range(0, 31));
        end
      endcase
      // upper data bits are random and must be dropped by the block
      write_reg(REG_FIT_MODE, {6'($urandom), mode});
      write_reg(REG_BLOCK_COUNT, {3'($urandom), cnt});
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
      end
      calm = (p % 4 == 3);

      while (sent < (p + 1) * PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 4) begin
          // refill the whole table, one load for each entry in turn
          for (int j = 0; j < BLOCKS; j++) begin
            push_item(KIND_LOAD, BLK_IDX_W'(j), AMOUNT_W'($urandom_range(0, 2048)));
          end
          sent += BLOCKS;
        end else begin
          random_item();
          sent++;
        end
      end
    end

    wait_idle();
    if (grants_due.size() != 0) errors++;
    if (errors == 0) begin
      $display("fit_policy_block_allocator_core verification clean");
    end else begin
      $display("fit_policy_block_allocator_core verification failed");
    end
    $finish;
  end

endmodule
